>>> rtl/rffe_fd_pkg.sv
package rffe_fd_pkg;

	localparam int unsigned FRAME_BITS = 25;
	localparam int unsigned BODY_BITS  = 24;
	localparam int unsigned CNT_W      = 5;
	localparam int unsigned FNUM_W     = 32;
	localparam int unsigned TS_W       = 64;

	// command classes
	localparam logic [2:0] CLASS_REG_WRITE = 3'd0;
	localparam logic [2:0] CLASS_REG_READ  = 3'd1;
	localparam logic [2:0] CLASS_EXT_WRITE = 3'd2;
	localparam logic [2:0] CLASS_EXT_READ  = 3'd3;
	localparam logic [2:0] CLASS_MASTER    = 3'd4;
	localparam logic [2:0] CLASS_HANDOVER  = 3'd5;

	typedef struct packed {
		logic            serial_bit;
		logic [TS_W-1:0] capture_us;
	} rffe_in_t;

	typedef struct packed {
		logic [3:0]            slave_id;
		logic [3:0]            command_code;
		logic [7:0]            reg_addr;
		logic [7:0]            data_byte;
		logic [2:0]            cmd_class;
		logic                  parity_ok;
		logic                  is_read;
		logic                  is_extended;
		logic [FNUM_W-1:0]     frame_number;
		logic [TS_W-1:0]       frame_time_us;
		logic [FRAME_BITS-1:0] raw_frame;
	} rffe_out_t;

	// completed frame handed from the accumulator to the decoder
	typedef struct packed {
		logic [FRAME_BITS-1:0] raw;
		logic [FNUM_W-1:0]     number;
		logic [TS_W-1:0]       time_us;
	} rffe_frame_t;

	function automatic logic [2:0] command_class_of(input logic [3:0] cmd);
		logic [2:0] cls;
		unique case (cmd[3:1])
			3'd0:    cls = CLASS_REG_WRITE;
			3'd1:    cls = CLASS_REG_READ;
			3'd2:    cls = CLASS_EXT_WRITE;
			3'd3:    cls = CLASS_EXT_WRITE;
			3'd4:    cls = CLASS_EXT_READ;
			3'd5:    cls = CLASS_EXT_READ;
			3'd6:    cls = CLASS_MASTER;
			default: cls = CLASS_HANDOVER;
		endcase
		return cls;
	endfunction

endpackage

>>> rtl/rffe_fd_acc.sv
module rffe_fd_acc
	import rffe_fd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  rffe_in_t    in_data,
	input  logic        dec_ready,
	output logic        frame_valid_s1,
	output rffe_frame_t frame_s1
);

	logic [FRAME_BITS-1:0] shift_q;
	logic [CNT_W-1:0]      count_q;
	logic [FNUM_W-1:0]     fnum_q;
	logic [FRAME_BITS-1:0] shift_next;
	logic                  accept;
	logic                  last_bit;

	assign in_stall   = frame_valid_s1 && !dec_ready;
	assign accept     = in_valid && !in_stall;
	assign shift_next = {shift_q[FRAME_BITS-2:0], in_data.serial_bit};
	// a stray count of 25 or more also closes the frame
	assign last_bit   = count_q >= CNT_W'(FRAME_BITS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q        <= '0;
			count_q        <= '0;
			fnum_q         <= FNUM_W'(1);
			frame_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (last_bit) begin
					shift_q <= '0;
					count_q <= '0;
					fnum_q  <= fnum_q + FNUM_W'(1);
				end else begin
					shift_q <= shift_next;
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (!frame_valid_s1 || dec_ready) begin
				frame_valid_s1 <= accept && last_bit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_bit) begin
			frame_s1.raw     <= shift_next;
			frame_s1.number  <= fnum_q;
			frame_s1.time_us <= in_data.capture_us;
		end
	end

endmodule

>>> rtl/rffe_fd_dec.sv
module rffe_fd_dec
	import rffe_fd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_valid_s1,
	input  rffe_frame_t frame_s1,
	output logic        dec_ready,
	output logic        out_valid,
	input  logic        out_stall,
	output rffe_out_t   out_data
);

	logic [BODY_BITS-1:0] body;
	logic [2:0]           cls;
	rffe_out_t            dec;
	logic                 out_valid_s2;
	rffe_out_t            out_data_s2;

	assign body      = frame_s1.raw[FRAME_BITS-1:1];
	assign cls       = command_class_of(body[19:16]);
	assign dec_ready = !out_valid_s2 || !out_stall;

	always_comb begin
		dec.slave_id         = body[23:20];
		dec.command_code     = body[19:16];
		dec.reg_addr         = body[15:8];
		dec.data_byte        = body[7:0];
		dec.cmd_class        = cls;
		// odd parity: parity bit equals the inverted xor of the body
		dec.parity_ok        = (~^body) == frame_s1.raw[0];
		dec.is_read          = (cls == CLASS_REG_READ) || (cls == CLASS_EXT_READ);
		dec.is_extended      = (cls == CLASS_EXT_WRITE) || (cls == CLASS_EXT_READ);
		dec.frame_number     = frame_s1.number;
		dec.frame_time_us    = frame_s1.time_us;
		dec.raw_frame        = frame_s1.raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (dec_ready) begin
			out_valid_s2 <= frame_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_ready && frame_valid_s1) begin
			out_data_s2 <= dec;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

endmodule

>>> rtl/rffe_frame_deserializer_top.sv
// a frame's result, once its 25th bit is taken, is registered in frame_s1 and then in the decode output register
// throughput: one serial bit per cycle while in_stall is low, no bubbles between frames
// an accumulator register and a decode output register separate the two channels
// reset (arst_n low) empties the shift register and bit count and sets the frame number to 1
module rffe_frame_deserializer_top
	import rffe_fd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  rffe_in_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output rffe_out_t out_data
);

	logic        dec_ready;
	logic        frame_valid_s1;
	rffe_frame_t frame_s1;

	rffe_fd_acc u_acc (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.dec_ready      (dec_ready),
		.frame_valid_s1 (frame_valid_s1),
		.frame_s1       (frame_s1)
	);

	rffe_fd_dec u_dec (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_valid_s1 (frame_valid_s1),
		.frame_s1       (frame_s1),
		.dec_ready      (dec_ready),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data)
	);

endmodule

>>> rtl/rffe_fd_checker.sv
module rffe_fd_checker
	import rffe_fd_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input rffe_in_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input rffe_out_t out_data
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("stalled input transaction changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result transaction changed");

	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.parity_ok ==
			((~^out_data.raw_frame[FRAME_BITS-1:1]) == out_data.raw_frame[0]))
		else $error("parity flag disagrees with raw frame");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.slave_id == out_data.raw_frame[24:21] &&
			out_data.data_byte == out_data.raw_frame[8:1])
		else $error("decoded fields disagree with raw frame");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.is_extended ==
			(out_data.cmd_class == CLASS_EXT_WRITE ||
			out_data.cmd_class == CLASS_EXT_READ))
		else $error("extended flag disagrees with command class");

endmodule

bind rffe_frame_deserializer_top rffe_fd_checker u_rffe_fd_checker (.*);
